/* rtl/stsm_pkg.sv */
// Shared types, codes and helpers for the sensor timestamp sync monitor.
`default_nettype none
package stsm_pkg;

  localparam int STREAMS   = 3;
  localparam int STAMP_W   = 63;
  localparam int OFFSET_W  = 64;
  localparam int CNT_W     = 32;
  localparam int TOL_W     = 48;
  localparam int QDEPTH_W  = 16;
  localparam int FRAME_W   = 8;
  localparam int SEL_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(20000000);
  localparam logic [QDEPTH_W-1:0] QDEPTH_RESET = QDEPTH_W'(10);
  localparam logic [FRAME_W-1:0]  FRAME_ANY    = '0;
  localparam logic [CNT_W-1:0]    CNT_MAX      = '1;

  // Operation codes
  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_TRIPLE  = 1'b1;

  // Stream select codes
  localparam logic [SEL_W-1:0] STREAM_IMAGE = 2'd0;
  localparam logic [SEL_W-1:0] STREAM_INFO  = 2'd1;
  localparam logic [SEL_W-1:0] STREAM_CLOUD = 2'd2;
  localparam logic [SEL_W-1:0] STREAM_NONE  = 2'd3;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_FRAME = 2'd1,
    FAULT_ORDER = 2'd2,
    FAULT_DELAY = 2'd3
  } fault_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOLERANCE   = 3'd0,
    CFG_QUEUE_DEPTH = 3'd1,
    CFG_FRAME_IMAGE = 3'd2,
    CFG_FRAME_INFO  = 3'd3,
    CFG_FRAME_CLOUD = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                opcode;
    logic [SEL_W-1:0]    stream_sel;
    logic [STAMP_W-1:0]  stamp;
    logic [FRAME_W-1:0]  frame_code;
    logic [STAMP_W-1:0]  image_stamp;
    logic [STAMP_W-1:0]  info_stamp;
    logic [STAMP_W-1:0]  cloud_stamp;
  } item_t;

  typedef struct packed {
    logic [TOL_W-1:0]                  tolerance_ns;
    logic [QDEPTH_W-1:0]               queue_depth;
    logic [STREAMS-1:0][FRAME_W-1:0]   expected_frame;
  } cfg_t;

  typedef struct packed {
    fault_t              fault;
    logic [OFFSET_W-1:0] offset_ns;
    logic [CNT_W-1:0]    dropped_total;
    logic [CNT_W-1:0]    wrong_frame_total;
    logic [CNT_W-1:0]    out_of_order_total;
    logic [CNT_W-1:0]    synced_total;
  } result_t;

  // Saturating increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  // Max minus min of three stamps
  function automatic logic [STAMP_W-1:0] spread3(input logic [STAMP_W-1:0] a,
                                                 input logic [STAMP_W-1:0] b,
                                                 input logic [STAMP_W-1:0] c);
    logic [STAMP_W-1:0] lo;
    logic [STAMP_W-1:0] hi;
    lo = a;
    hi = a;
    if (b < lo) lo = b;
    if (b > hi) hi = b;
    if (c < lo) lo = c;
    if (c > hi) hi = c;
    return hi - lo;
  endfunction

endpackage
`default_nettype wire

/* rtl/stsm_core.sv */
// Check core: per-stream tracking state, fault decision and counters for one beat.
`default_nettype none
module stsm_core
  import stsm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    item_valid,
  input  wire item_t   item,
  input  wire cfg_t    cfg,
  output result_t      result
);

  logic [STREAMS-1:0][STAMP_W-1:0] last_r, last_nxt;
  logic [STREAMS-1:0]              seen_r, seen_nxt;
  logic [STREAMS-1:0][CNT_W-1:0]   acc_r, acc_nxt;
  logic [OFFSET_W-1:0]             offset_r, offset_nxt;
  logic [CNT_W-1:0]                dropped_r, dropped_nxt;
  logic [CNT_W-1:0]                wrong_r, wrong_nxt;
  logic [CNT_W-1:0]                order_r, order_nxt;
  logic [CNT_W-1:0]                synced_r, synced_nxt;
  fault_t                          fault;

  logic [FRAME_W-1:0] exp_sel;
  logic [STAMP_W-1:0] last_sel;
  logic               seen_sel;
  logic [CNT_W-1:0]   acc_sel_inc;
  logic [CNT_W-1:0]   acc_min;
  logic [CNT_W:0]     lead_limit;
  logic               all_equal;

  logic [STREAMS-1:0][STAMP_W-1:0] last_upd;
  logic [STREAMS-1:0]              seen_upd;
  logic [STREAMS-1:0][CNT_W-1:0]   acc_upd;

  // Pick the addressed stream's state and its state after an accepted beat
  always_comb begin
    exp_sel  = FRAME_ANY;
    last_sel = '0;
    seen_sel = 1'b0;
    acc_sel_inc = '0;
    last_upd = last_r;
    seen_upd = seen_r;
    acc_upd  = acc_r;
    for (int i = 0; i < STREAMS; i++) begin
      if (item.stream_sel == SEL_W'(i)) begin
        exp_sel     = cfg.expected_frame[i];
        last_sel    = last_r[i];
        seen_sel    = seen_r[i];
        acc_sel_inc = sat_inc(acc_r[i]);
        last_upd[i] = item.stamp;
        seen_upd[i] = 1'b1;
        acc_upd[i]  = sat_inc(acc_r[i]);
      end
    end
  end

  // Slowest stream after this beat's count update
  always_comb begin
    acc_min = acc_upd[0];
    for (int i = 1; i < STREAMS; i++) begin
      if (acc_upd[i] < acc_min) acc_min = acc_upd[i];
    end
    lead_limit = {1'b0, acc_min} + (CNT_W+1)'(cfg.queue_depth);
    all_equal  = (acc_upd[0] == acc_upd[1]) && (acc_upd[1] == acc_upd[2]) && (&seen_upd);
  end

  // Next state and fault code
  always_comb begin
    last_nxt    = last_r;
    seen_nxt    = seen_r;
    acc_nxt     = acc_r;
    offset_nxt  = offset_r;
    dropped_nxt = dropped_r;
    wrong_nxt   = wrong_r;
    order_nxt   = order_r;
    synced_nxt  = synced_r;
    fault       = FAULT_NONE;
    if (item.opcode == OP_TRIPLE) begin
      offset_nxt = {1'b0, item.cloud_stamp} - {1'b0, item.image_stamp};
      if ((TOL_W+STAMP_W)'(spread3(item.image_stamp, item.info_stamp, item.cloud_stamp))
          > (TOL_W+STAMP_W)'(cfg.tolerance_ns)) begin
        dropped_nxt = sat_inc(dropped_r);
        fault       = FAULT_DELAY;
      end else begin
        synced_nxt = sat_inc(synced_r);
      end
    end else if (item.stream_sel != STREAM_NONE) begin
      if (exp_sel != FRAME_ANY && item.frame_code != exp_sel) begin
        wrong_nxt   = sat_inc(wrong_r);
        dropped_nxt = sat_inc(dropped_r);
        fault       = FAULT_FRAME;
      end else if (seen_sel && item.stamp <= last_sel) begin
        order_nxt   = sat_inc(order_r);
        dropped_nxt = sat_inc(dropped_r);
        fault       = FAULT_ORDER;
      end else begin
        last_nxt = last_upd;
        seen_nxt = seen_upd;
        acc_nxt  = acc_upd;
        if ({1'b0, acc_sel_inc} > lead_limit) begin
          dropped_nxt = sat_inc(dropped_r);
          fault       = FAULT_DELAY;
        end else if (all_equal) begin
          offset_nxt = {1'b0, last_upd[2]} - {1'b0, last_upd[0]};
          if ((TOL_W+STAMP_W)'(spread3(last_upd[0], last_upd[1], last_upd[2]))
              > (TOL_W+STAMP_W)'(cfg.tolerance_ns)) begin
            dropped_nxt = sat_inc(dropped_r);
            fault       = FAULT_DELAY;
          end
        end
      end
    end
  end

  // Commit state on each beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= '0;
      seen_r    <= '0;
      acc_r     <= '0;
      offset_r  <= '0;
      dropped_r <= '0;
      wrong_r   <= '0;
      order_r   <= '0;
      synced_r  <= '0;
    end else if (item_valid) begin
      last_r    <= last_nxt;
      seen_r    <= seen_nxt;
      acc_r     <= acc_nxt;
      offset_r  <= offset_nxt;
      dropped_r <= dropped_nxt;
      wrong_r   <= wrong_nxt;
      order_r   <= order_nxt;
      synced_r  <= synced_nxt;
    end
  end

  // Result reflects state after this beat
  always_comb begin
    result.fault              = fault;
    result.offset_ns          = offset_nxt;
    result.dropped_total      = dropped_nxt;
    result.wrong_frame_total  = wrong_nxt;
    result.out_of_order_total = order_nxt;
    result.synced_total       = synced_nxt;
  end

endmodule
`default_nettype wire

/* rtl/sensor_timestamp_sync_monitor.sv */
// Top level: beat handshakes, configuration registers and result register.
`default_nettype none
// Watches image, camera info and point cloud metadata beats and reports one result per
// input beat: a fault code, the latest cloud-minus-image offset and four saturating
// counters. One beat is taken every cycle while the input is not stalled; a result is
// offered once its beat has passed the input register and the check core into the
// result register. The rate is set by the per-stream state update in the check core,
// which is combinational. While a finished result is stalled the input register still
// takes one more beat; the input then stalls until the result is taken. Configuration
// writes are always ready and take effect on the next beat; write them only while no beat
// is in flight.
module sensor_timestamp_sync_monitor
  import stsm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_opcode,
  input  wire logic [SEL_W-1:0]           in_stream_sel,
  input  wire logic [STAMP_W-1:0]         in_stamp,
  input  wire logic [FRAME_W-1:0]         in_frame_code,
  input  wire logic [STAMP_W-1:0]         in_image_stamp,
  input  wire logic [STAMP_W-1:0]         in_info_stamp,
  input  wire logic [STAMP_W-1:0]         in_cloud_stamp,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      out_fault,
  output logic signed [OFFSET_W-1:0]      out_offset_ns,
  output logic [CNT_W-1:0]                out_dropped_total,
  output logic [CNT_W-1:0]                out_wrong_frame_total,
  output logic [CNT_W-1:0]                out_out_of_order_total,
  output logic [CNT_W-1:0]                out_synced_total,
  // configuration write channel
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DAT_W-1:0]       cfg_data
);

  cfg_t    cfg_r;
  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t res_r;
  result_t core_res;
  logic    out_free;
  logic    s1_adv;
  logic    in_acc;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tolerance_ns   <= TOL_RESET;
      cfg_r.queue_depth    <= QDEPTH_RESET;
      cfg_r.expected_frame <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TOLERANCE:   cfg_r.tolerance_ns      <= cfg_data[TOL_W-1:0];
        CFG_QUEUE_DEPTH: cfg_r.queue_depth       <= cfg_data[QDEPTH_W-1:0];
        CFG_FRAME_IMAGE: cfg_r.expected_frame[0] <= cfg_data[FRAME_W-1:0];
        CFG_FRAME_INFO:  cfg_r.expected_frame[1] <= cfg_data[FRAME_W-1:0];
        CFG_FRAME_CLOUD: cfg_r.expected_frame[2] <= cfg_data[FRAME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake control
  assign out_free      = !out_valid_r || !out_stall;
  assign s1_adv        = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_acc        = in_valid && !in_stall;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture input beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.opcode      <= in_opcode;
      s1_item_r.stream_sel  <= in_stream_sel;
      s1_item_r.stamp       <= in_stamp;
      s1_item_r.frame_code  <= in_frame_code;
      s1_item_r.image_stamp <= in_image_stamp;
      s1_item_r.info_stamp  <= in_info_stamp;
      s1_item_r.cloud_stamp <= in_cloud_stamp;
    end
  end

  stsm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_adv),
    .item       (s1_item_r),
    .cfg        (cfg_r),
    .result     (core_res)
  );

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= core_res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_fault              = res_r.fault;
  assign out_offset_ns          = res_r.offset_ns;
  assign out_dropped_total      = res_r.dropped_total;
  assign out_wrong_frame_total  = res_r.wrong_frame_total;
  assign out_out_of_order_total = res_r.out_of_order_total;
  assign out_synced_total       = res_r.synced_total;

`ifndef SYNTHESIS
  // Input side stalls only with a beat parked in the input register
  a_stall_needs_parked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // Any fault must be counted as a drop
  a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.fault != FAULT_NONE) |-> (res_r.dropped_total != '0))
    else $error("fault reported with zero drop count");

  // Wrong frame must be counted
  a_frame_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.fault == FAULT_FRAME) |-> (res_r.wrong_frame_total != '0))
    else $error("wrong frame reported with zero count");

  // Registered drop count is never below the check core's drop count for the beat just taken
  a_drop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (res_r.dropped_total >= $past(core_res.dropped_total)))
    else $error("drop count decreased");
`endif

endmodule
`default_nettype wire
